// File: design/canfd_txq_pkg.sv
// shared types, constants and functions of the can fd transmit queue arbiter
package canfd_txq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W        = 29;
    localparam int LEN_W       = 7;
    localparam int TAG_W       = 8;
    localparam int DLC_W       = 4;
    localparam int STATUS_W    = 3;
    localparam int OPCODE_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 1;

    localparam logic [ID_W-1:0]  ID_MASK_STD     = 29'h7FF;
    localparam logic [LEN_W-1:0] FD_MAX_LEN      = 7'd64;
    localparam logic [LEN_W-1:0] CLASSIC_MAX_LEN = 7'd8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ_CLASSIC = 2'd0,
        OP_ENQ_FD      = 2'd1,
        OP_OFFER       = 2'd2,
        OP_RESERVED    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK             = 3'd0,
        STS_NOT_CONFIGURED = 3'd1,
        STS_NOT_SUPPORTED  = 3'd2,
        STS_BAD_ARG        = 3'd3,
        STS_FULL           = 3'd4,
        STS_NOTHING        = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONFIGURED = 2'd0,
        CFG_FD_ENABLE  = 2'd1,
        CFG_BRS_ENABLE = 2'd2,
        CFG_ESI_ENABLE = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic             ext;
        logic             rtr;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } frame_desc_t;

    typedef struct packed {
        logic load;
        logic exec;
    } txq_cmd_t;

    function automatic logic [DLC_W-1:0] len_to_dlc(input logic [LEN_W-1:0] n);
        logic [DLC_W-1:0] dlc;
        if (n <= 7'd8) begin
            dlc = n[DLC_W-1:0];
        end else if (n <= 7'd12) begin
            dlc = 4'd9;
        end else if (n <= 7'd16) begin
            dlc = 4'd10;
        end else if (n <= 7'd20) begin
            dlc = 4'd11;
        end else if (n <= 7'd24) begin
            dlc = 4'd12;
        end else if (n <= 7'd32) begin
            dlc = 4'd13;
        end else if (n <= 7'd48) begin
            dlc = 4'd14;
        end else begin
            dlc = 4'd15;
        end
        return dlc;
    endfunction

endpackage

// File: design/canfd_txq_ctrl.sv
// controller state machine of the can fd transmit queue arbiter
module canfd_txq_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    done,
    output canfd_txq_pkg::txq_cmd_t cmd
);
    import canfd_txq_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       done_reg;
    logic       done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

// File: design/canfd_txq_datapath.sv
// queues, retry slots, arbitration and result registers of the transmit queue arbiter
module canfd_txq_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  canfd_txq_pkg::txq_cmd_t                cmd,
    input  logic                                   cfg_we,
    input  logic [canfd_txq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [canfd_txq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [canfd_txq_pkg::OPCODE_W-1:0]     opcode,
    input  logic [canfd_txq_pkg::ID_W-1:0]         frame_id,
    input  logic                                   extended_id,
    input  logic                                   remote_request,
    input  logic [canfd_txq_pkg::LEN_W-1:0]        payload_length,
    input  logic [canfd_txq_pkg::TAG_W-1:0]        buffer_tag,
    input  logic                                   hw_accepts,
    output logic [canfd_txq_pkg::STATUS_W-1:0]     status,
    output logic                                   frame_valid,
    output logic [canfd_txq_pkg::ID_W-1:0]         tx_id,
    output logic                                   tx_extended,
    output logic                                   tx_remote,
    output logic [canfd_txq_pkg::DLC_W-1:0]        tx_dlc,
    output logic                                   tx_fd_format,
    output logic                                   tx_bit_rate_switch,
    output logic                                   tx_error_state,
    output logic [canfd_txq_pkg::TAG_W-1:0]        tx_tag,
    output logic                                   held_for_retry
);
    import canfd_txq_pkg::*;

    typedef struct packed {
        status_t          status;
        logic             frame_valid;
        logic [ID_W-1:0]  id;
        logic             ext;
        logic             remote;
        logic [DLC_W-1:0] dlc;
        logic             fd_format;
        logic             brs;
        logic             esi;
        logic [TAG_W-1:0] tag;
        logic             held;
    } tx_result_t;

    // side 0 is classic, side 1 is fd
    frame_desc_t mem_classic [QUEUE_DEPTH];
    frame_desc_t mem_fd      [QUEUE_DEPTH];

    logic        configured_reg;
    logic        fd_enable_reg;
    logic        brs_enable_reg;
    logic        esi_enable_reg;

    opcode_t     op_reg;
    frame_desc_t fin_reg;
    logic        accept_reg;
    frame_desc_t head_reg [2];

    logic [CNT_W-1:0] count_reg [2];
    logic [CNT_W-1:0] count_next [2];
    logic [PTR_W-1:0] rd_reg [2];
    logic [PTR_W-1:0] rd_next [2];
    logic             retry_valid_reg [2];
    logic             retry_valid_next [2];
    frame_desc_t      retry_desc_reg [2];
    frame_desc_t      retry_desc_next [2];
    logic             prefer_fd_reg;
    logic             prefer_fd_next;

    tx_result_t  result_reg;
    tx_result_t  result_next;

    logic        push_classic;
    logic        push_fd;
    logic [PTR_W-1:0] wr_addr;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            configured_reg <= 1'b0;
            fd_enable_reg  <= 1'b0;
            brs_enable_reg <= 1'b0;
            esi_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONFIGURED: configured_reg <= cfg_wdata[0];
                CFG_FD_ENABLE:  fd_enable_reg  <= cfg_wdata[0];
                CFG_BRS_ENABLE: brs_enable_reg <= cfg_wdata[0];
                CFG_ESI_ENABLE: esi_enable_reg <= cfg_wdata[0];
                default:        configured_reg <= configured_reg;
            endcase
        end
    end

    // input capture at transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= opcode_t'(opcode);
            fin_reg.id     <= frame_id;
            fin_reg.ext    <= extended_id;
            fin_reg.rtr    <= remote_request;
            fin_reg.len    <= payload_length;
            fin_reg.tag    <= buffer_tag;
            accept_reg     <= hw_accepts;
        end
    end

    // queue memories with registered head read
    always_ff @(posedge clk)
    begin
        if (push_classic)
        begin
            mem_classic[wr_addr] <= fin_reg;
        end
        if (cmd.load)
        begin
            head_reg[0] <= mem_classic[rd_reg[0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fd)
        begin
            mem_fd[wr_addr] <= fin_reg;
        end
        if (cmd.load)
        begin
            head_reg[1] <= mem_fd[rd_reg[1]];
        end
    end

    // queue and arbitration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 2; s++)
            begin
                count_reg[s]       <= '0;
                rd_reg[s]          <= '0;
                retry_valid_reg[s] <= 1'b0;
                retry_desc_reg[s]  <= '0;
            end
            prefer_fd_reg <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < 2; s++)
            begin
                count_reg[s]       <= count_next[s];
                rd_reg[s]          <= rd_next[s];
                retry_valid_reg[s] <= retry_valid_next[s];
                retry_desc_reg[s]  <= retry_desc_next[s];
            end
            prefer_fd_reg <= prefer_fd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        logic             is_fd;
        logic [0:0]       tgt;
        logic [PTR_W:0]   wr_sum;
        logic             avail [2];
        logic             hit;
        logic [0:0]       side;
        logic             from_retry;
        frame_desc_t      f;
        logic [LEN_W-1:0] dlc_len;

        for (int s = 0; s < 2; s++)
        begin
            count_next[s]       = count_reg[s];
            rd_next[s]          = rd_reg[s];
            retry_valid_next[s] = retry_valid_reg[s];
            retry_desc_next[s]  = retry_desc_reg[s];
        end
        prefer_fd_next = prefer_fd_reg;
        result_next    = '0;
        result_next.status = STS_OK;
        push_classic   = 1'b0;
        push_fd        = 1'b0;

        is_fd = (op_reg == OP_ENQ_FD);
        tgt   = is_fd;
        wr_sum = (PTR_W + 1)'(rd_reg[tgt]) + (PTR_W + 1)'(count_reg[tgt]);
        if (wr_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
        begin
            wr_sum = wr_sum - (PTR_W + 1)'(QUEUE_DEPTH);
        end
        wr_addr = wr_sum[PTR_W-1:0];

        avail[0] = retry_valid_reg[0] || (count_reg[0] != '0);
        avail[1] = fd_enable_reg && (retry_valid_reg[1] || (count_reg[1] != '0));
        hit  = 1'b1;
        side = prefer_fd_reg;
        if (!avail[prefer_fd_reg])
        begin
            side = !prefer_fd_reg;
            hit  = avail[!prefer_fd_reg];
        end
        from_retry = retry_valid_reg[side];
        f = from_retry ? retry_desc_reg[side] : head_reg[side];
        dlc_len = (side == 1'b1 && f.len > FD_MAX_LEN) ? FD_MAX_LEN : f.len;

        if (cmd.exec)
        begin
            case (op_reg)
                OP_ENQ_CLASSIC, OP_ENQ_FD:
                begin
                    if (!configured_reg)
                    begin
                        result_next.status = STS_NOT_CONFIGURED;
                    end
                    else if (is_fd && !fd_enable_reg)
                    begin
                        result_next.status = STS_NOT_SUPPORTED;
                    end
                    else if (!fin_reg.ext && (fin_reg.id > ID_MASK_STD))
                    begin
                        result_next.status = STS_BAD_ARG;
                    end
                    else if (fin_reg.len > (is_fd ? FD_MAX_LEN : CLASSIC_MAX_LEN))
                    begin
                        result_next.status = STS_BAD_ARG;
                    end
                    else if (count_reg[tgt] == CNT_W'(QUEUE_DEPTH))
                    begin
                        result_next.status = STS_FULL;
                    end
                    else
                    begin
                        push_classic    = !is_fd;
                        push_fd         = is_fd;
                        count_next[tgt] = count_reg[tgt] + 1'b1;
                    end
                end
                OP_OFFER:
                begin
                    if (!configured_reg)
                    begin
                        result_next.status = STS_NOT_CONFIGURED;
                    end
                    else if (!hit)
                    begin
                        result_next.status = STS_NOTHING;
                    end
                    else
                    begin
                        if (!from_retry)
                        begin
                            count_next[side] = count_reg[side] - 1'b1;
                            rd_next[side] = (rd_reg[side] == PTR_W'(QUEUE_DEPTH - 1))
                                            ? '0 : rd_reg[side] + 1'b1;
                        end
                        if (accept_reg)
                        begin
                            retry_valid_next[side] = 1'b0;
                            retry_desc_next[side]  = '0;
                            prefer_fd_next         = !side;
                        end
                        else
                        begin
                            retry_valid_next[side] = 1'b1;
                            retry_desc_next[side]  = f;
                        end
                        result_next.frame_valid = 1'b1;
                        result_next.id          = f.ext ? f.id : (f.id & ID_MASK_STD);
                        result_next.ext         = f.ext;
                        result_next.remote      = side ? 1'b0 : f.rtr;
                        result_next.dlc         = len_to_dlc(dlc_len);
                        result_next.fd_format   = side;
                        result_next.brs         = side & brs_enable_reg;
                        result_next.esi         = side & esi_enable_reg;
                        result_next.tag         = f.tag;
                        result_next.held        = !accept_reg;
                    end
                end
                default:
                begin
                    result_next.status = STS_BAD_ARG;
                end
            endcase
        end
    end

    assign status             = result_reg.status;
    assign frame_valid        = result_reg.frame_valid;
    assign tx_id              = result_reg.id;
    assign tx_extended        = result_reg.ext;
    assign tx_remote          = result_reg.remote;
    assign tx_dlc             = result_reg.dlc;
    assign tx_fd_format       = result_reg.fd_format;
    assign tx_bit_rate_switch = result_reg.brs;
    assign tx_error_state     = result_reg.esi;
    assign tx_tag             = result_reg.tag;
    assign held_for_retry     = result_reg.held;

endmodule

// File: design/canfd_tx_queue_arbiter_core.sv
// top level of the can fd transmit queue arbiter
// result and done are registered together at the end of the execute state that follows the start transfer
// a new transfer is taken only in idle, after the execute state that uses the registered queue head read
// busy is high for the one execute cycle; results cannot be stalled
// reset: asynchronous active low, clears configuration, counts, pointers and retry slots
// queue contents are not cleared; only written entries are ever read
module canfd_tx_queue_arbiter_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   cfg_we,
    input  logic [canfd_txq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [canfd_txq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [canfd_txq_pkg::OPCODE_W-1:0]     opcode,
    input  logic [canfd_txq_pkg::ID_W-1:0]         frame_id,
    input  logic                                   extended_id,
    input  logic                                   remote_request,
    input  logic [canfd_txq_pkg::LEN_W-1:0]        payload_length,
    input  logic [canfd_txq_pkg::TAG_W-1:0]        buffer_tag,
    input  logic                                   hw_accepts,
    output logic                                   done,
    output logic [canfd_txq_pkg::STATUS_W-1:0]     status,
    output logic                                   frame_valid,
    output logic [canfd_txq_pkg::ID_W-1:0]         tx_id,
    output logic                                   tx_extended,
    output logic                                   tx_remote,
    output logic [canfd_txq_pkg::DLC_W-1:0]        tx_dlc,
    output logic                                   tx_fd_format,
    output logic                                   tx_bit_rate_switch,
    output logic                                   tx_error_state,
    output logic [canfd_txq_pkg::TAG_W-1:0]        tx_tag,
    output logic                                   held_for_retry
);
    import canfd_txq_pkg::*;

    txq_cmd_t cmd;

    canfd_txq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    canfd_txq_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .opcode             (opcode),
        .frame_id           (frame_id),
        .extended_id        (extended_id),
        .remote_request     (remote_request),
        .payload_length     (payload_length),
        .buffer_tag         (buffer_tag),
        .hw_accepts         (hw_accepts),
        .status             (status),
        .frame_valid        (frame_valid),
        .tx_id              (tx_id),
        .tx_extended        (tx_extended),
        .tx_remote          (tx_remote),
        .tx_dlc             (tx_dlc),
        .tx_fd_format       (tx_fd_format),
        .tx_bit_rate_switch (tx_bit_rate_switch),
        .tx_error_state     (tx_error_state),
        .tx_tag             (tx_tag),
        .held_for_retry     (held_for_retry)
    );

endmodule

// File: dv/canfd_txq_checker.sv
// checker that predicts and compares every result of the can fd transmit queue arbiter
`timescale 1ns / 1ps
module canfd_txq_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 cfg_we,
    input  logic [canfd_txq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [canfd_txq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [canfd_txq_pkg::OPCODE_W-1:0]   opcode,
    input  logic [canfd_txq_pkg::ID_W-1:0]       frame_id,
    input  logic                                 extended_id,
    input  logic                                 remote_request,
    input  logic [canfd_txq_pkg::LEN_W-1:0]      payload_length,
    input  logic [canfd_txq_pkg::TAG_W-1:0]      buffer_tag,
    input  logic                                 hw_accepts,
    input  logic                                 done,
    input  logic [canfd_txq_pkg::STATUS_W-1:0]   status,
    input  logic                                 frame_valid,
    input  logic [canfd_txq_pkg::ID_W-1:0]       tx_id,
    input  logic                                 tx_extended,
    input  logic                                 tx_remote,
    input  logic [canfd_txq_pkg::DLC_W-1:0]      tx_dlc,
    input  logic                                 tx_fd_format,
    input  logic                                 tx_bit_rate_switch,
    input  logic                                 tx_error_state,
    input  logic [canfd_txq_pkg::TAG_W-1:0]      tx_tag,
    input  logic                                 held_for_retry,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked,
    output int                                   holds,
    output int                                   fulls
);
    import canfd_txq_pkg::*;

    localparam int SIDE_CLASSIC = 0;
    localparam int SIDE_FD      = 1;

    typedef struct packed {
        status_t          status;
        logic             frame_valid;
        logic [ID_W-1:0]  tx_id;
        logic             tx_extended;
        logic             tx_remote;
        logic [DLC_W-1:0] tx_dlc;
        logic             tx_fd_format;
        logic             tx_bit_rate_switch;
        logic             tx_error_state;
        logic [TAG_W-1:0] tx_tag;
        logic             held_for_retry;
    } txq_result_t;

    logic        reg_configured;
    logic        reg_fd_en;
    logic        reg_brs_en;
    logic        reg_esi_en;
    frame_desc_t side_mem [2][QUEUE_DEPTH];
    int          side_count [2];
    int          side_rd [2];
    logic        retry_valid [2];
    frame_desc_t retry_desc [2];
    logic        prefer_fd;

    txq_result_t expected_q [$];
    txq_result_t seen_result;
    txq_result_t want_result;
    frame_desc_t in_desc;

    function automatic logic [DLC_W-1:0] dlc_for_len(input logic [LEN_W-1:0] n);
        int v;
        v = int'(n);
        if (v <= 8)
            return v[DLC_W-1:0];
        if (v <= 24)
            return 4'((v - 9) / 4 + 9);
        if (v <= 32)
            return 4'd13;
        if (v <= 48)
            return 4'd14;
        return 4'd15;
    endfunction

    // frame_valid low in the return value means this side had nothing to show
    function automatic txq_result_t present_side(input int side, input logic accept);
        txq_result_t r;
        frame_desc_t f;
        logic [LEN_W-1:0] len;
        r = '0;
        if (side == SIDE_FD && !reg_fd_en)
            return r;
        if (retry_valid[side])
        begin
            f = retry_desc[side];
        end
        else if (side_count[side] == 0)
        begin
            return r;
        end
        else
        begin
            f = side_mem[side][side_rd[side]];
            side_rd[side] = (side_rd[side] + 1) % QUEUE_DEPTH;
            side_count[side]--;
        end
        len = f.len;
        if (side == SIDE_FD && len > FD_MAX_LEN)
            len = FD_MAX_LEN;
        r.frame_valid        = 1'b1;
        r.tx_id              = f.ext ? f.id : (f.id & ID_MASK_STD);
        r.tx_extended        = f.ext;
        r.tx_remote          = (side == SIDE_FD) ? 1'b0 : f.rtr;
        r.tx_dlc             = dlc_for_len(len);
        r.tx_fd_format       = (side == SIDE_FD);
        r.tx_bit_rate_switch = (side == SIDE_FD) && reg_brs_en;
        r.tx_error_state     = (side == SIDE_FD) && reg_esi_en;
        r.tx_tag             = f.tag;
        if (accept)
        begin
            retry_valid[side] = 1'b0;
            retry_desc[side]  = '0;
            prefer_fd         = (side == SIDE_CLASSIC);
        end
        else
        begin
            retry_valid[side] = 1'b1;
            retry_desc[side]  = f;
            r.held_for_retry  = 1'b1;
        end
        return r;
    endfunction

    function automatic txq_result_t predict_transfer(input opcode_t op, input frame_desc_t f,
                                                     input logic accept);
        txq_result_t r;
        int side;
        int first;
        logic [LEN_W-1:0] max_len;
        r = '0;
        case (op)
            OP_ENQ_CLASSIC, OP_ENQ_FD:
            begin
                side    = (op == OP_ENQ_FD) ? SIDE_FD : SIDE_CLASSIC;
                max_len = (op == OP_ENQ_FD) ? FD_MAX_LEN : CLASSIC_MAX_LEN;
                if (!reg_configured)
                    r.status = STS_NOT_CONFIGURED;
                else if (op == OP_ENQ_FD && !reg_fd_en)
                    r.status = STS_NOT_SUPPORTED;
                else if (!f.ext && f.id > ID_MASK_STD)
                    r.status = STS_BAD_ARG;
                else if (f.len > max_len)
                    r.status = STS_BAD_ARG;
                else if (side_count[side] >= QUEUE_DEPTH)
                    r.status = STS_FULL;
                else
                begin
                    if (side == SIDE_FD)
                        f.rtr = 1'b0;
                    side_mem[side][(side_rd[side] + side_count[side]) % QUEUE_DEPTH] = f;
                    side_count[side]++;
                    r.status = STS_OK;
                end
            end
            OP_OFFER:
            begin
                if (!reg_configured)
                begin
                    r.status = STS_NOT_CONFIGURED;
                end
                else
                begin
                    first = prefer_fd ? SIDE_FD : SIDE_CLASSIC;
                    r = present_side(first, accept);
                    if (!r.frame_valid)
                        r = present_side(1 - first, accept);
                    r.status = r.frame_valid ? STS_OK : STS_NOTHING;
                end
            end
            default:
                r.status = STS_BAD_ARG;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("%0t mismatch on %s: got %0h want %0h", $time, what, got_v, want_v);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got_v,
                               input logic [31:0] want_v);
        if (got_v !== want_v)
            report_mismatch(what, got_v, want_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_configured = 1'b0;
            reg_fd_en      = 1'b0;
            reg_brs_en     = 1'b0;
            reg_esi_en     = 1'b0;
            prefer_fd      = 1'b0;
            for (int s = 0; s < 2; s++)
            begin
                side_count[s]  = 0;
                side_rd[s]     = 0;
                retry_valid[s] = 1'b0;
                retry_desc[s]  = '0;
            end
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                seen_result.status             = status_t'(status);
                seen_result.frame_valid        = frame_valid;
                seen_result.tx_id              = tx_id;
                seen_result.tx_extended        = tx_extended;
                seen_result.tx_remote          = tx_remote;
                seen_result.tx_dlc             = tx_dlc;
                seen_result.tx_fd_format       = tx_fd_format;
                seen_result.tx_bit_rate_switch = tx_bit_rate_switch;
                seen_result.tx_error_state     = tx_error_state;
                seen_result.tx_tag             = tx_tag;
                seen_result.held_for_retry     = held_for_retry;
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with no transfer waiting, status", 32'(status),
                                    '0);
                end
                else
                begin
                    want_result = expected_q.pop_front();
                    check_field("status", 32'(seen_result.status),
                                32'(want_result.status));
                    check_field("frame_valid", 32'(seen_result.frame_valid),
                                32'(want_result.frame_valid));
                    check_field("tx_id", 32'(seen_result.tx_id), 32'(want_result.tx_id));
                    check_field("tx_extended", 32'(seen_result.tx_extended),
                                32'(want_result.tx_extended));
                    check_field("tx_remote", 32'(seen_result.tx_remote),
                                32'(want_result.tx_remote));
                    check_field("tx_dlc", 32'(seen_result.tx_dlc), 32'(want_result.tx_dlc));
                    check_field("tx_fd_format", 32'(seen_result.tx_fd_format),
                                32'(want_result.tx_fd_format));
                    check_field("tx_bit_rate_switch", 32'(seen_result.tx_bit_rate_switch),
                                32'(want_result.tx_bit_rate_switch));
                    check_field("tx_error_state", 32'(seen_result.tx_error_state),
                                32'(want_result.tx_error_state));
                    check_field("tx_tag", 32'(seen_result.tx_tag), 32'(want_result.tx_tag));
                    check_field("held_for_retry", 32'(seen_result.held_for_retry),
                                32'(want_result.held_for_retry));
                    checked++;
                    if (want_result.held_for_retry)
                        holds++;
                    if (want_result.status == STS_FULL)
                        fulls++;
                end
            end
            if (cfg_we === 1'b1)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CONFIGURED: reg_configured = cfg_wdata[0];
                    CFG_FD_ENABLE:  reg_fd_en      = cfg_wdata[0];
                    CFG_BRS_ENABLE: reg_brs_en     = cfg_wdata[0];
                    CFG_ESI_ENABLE: reg_esi_en     = cfg_wdata[0];
                    default:        ;
                endcase
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                in_desc.id  = frame_id;
                in_desc.ext = extended_id;
                in_desc.rtr = remote_request;
                in_desc.len = payload_length;
                in_desc.tag = buffer_tag;
                expected_q.push_back(predict_transfer(opcode_t'(opcode), in_desc, hw_accepts));
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: dv/tb.sv
// testbench top for the can fd transmit queue arbiter: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb;
    import canfd_txq_pkg::*;

    localparam int STALL_LIMIT  = 500;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 215;
    localparam int UNCFG_ITEMS  = 40;
    localparam int BURST_ITEMS  = 32;
    localparam int MAX_GAP      = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic [OPCODE_W-1:0]   opcode;
    logic [ID_W-1:0]       frame_id;
    logic                  extended_id;
    logic                  remote_request;
    logic [LEN_W-1:0]      payload_length;
    logic [TAG_W-1:0]      buffer_tag;
    logic                  hw_accepts;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic                  frame_valid;
    logic [ID_W-1:0]       tx_id;
    logic                  tx_extended;
    logic                  tx_remote;
    logic [DLC_W-1:0]      tx_dlc;
    logic                  tx_fd_format;
    logic                  tx_bit_rate_switch;
    logic                  tx_error_state;
    logic [TAG_W-1:0]      tx_tag;
    logic                  held_for_retry;

    int fail_count;
    int pending;
    int checked;
    int holds;
    int fulls;

    int quiet_cycles;
    int idle_pct;
    int n_enq;
    int n_offer;
    int n_reserved;
    int n_settings;

    // per phase: register bits {esi, brs, fd, configured} and sender idle percentage
    bit [3:0] phase_regs [NUM_PHASES] = '{4'b1111, 4'b0001, 4'b1011, 4'b0000,
                                          4'b0111, 4'b0011, 4'b1101, 4'b1111};
    int       phase_idle [NUM_PHASES] = '{0, 78, 0, 0, 8, 78, 0, 8};
    int       fd_len_edges [16] = '{0, 8, 9, 12, 13, 16, 17, 20, 21, 24, 25, 32, 33, 48,
                                    49, 64};

    canfd_tx_queue_arbiter_core dut (.*);

    canfd_txq_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_cmd(input opcode_t op, input logic [ID_W-1:0] id, input logic ext,
                            input logic rtr, input logic [LEN_W-1:0] len,
                            input logic [TAG_W-1:0] tag, input logic acc);
        int gap;
        opcode         <= op;
        frame_id       <= id;
        extended_id    <= ext;
        remote_request <= rtr;
        payload_length <= len;
        buffer_tag     <= tag;
        hw_accepts     <= acc;
        start          <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        case (op)
            OP_ENQ_CLASSIC, OP_ENQ_FD: n_enq++;
            OP_OFFER:                  n_offer++;
            default:                   n_reserved++;
        endcase
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    // registers change only once every transfer in flight has its result
    task automatic load_regs(input logic cfgd, input logic fd, input logic brs,
                             input logic esi);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        write_reg(CFG_CONFIGURED, cfgd);
        write_reg(CFG_FD_ENABLE, fd);
        write_reg(CFG_BRS_ENABLE, brs);
        write_reg(CFG_ESI_ENABLE, esi);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic random_item(input int enq_pct);
        int r;
        opcode_t op;
        logic ext;
        logic [ID_W-1:0] id;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 2)
            op = OP_RESERVED;
        else if (r < 2 + enq_pct)
            op = ($urandom_range(0, 1) != 0) ? OP_ENQ_FD : OP_ENQ_CLASSIC;
        else
            op = OP_OFFER;
        ext = 1'($urandom_range(0, 1));
        if (ext || $urandom_range(0, 19) == 0)
            id = ID_W'($urandom);
        else
            id = ID_W'($urandom_range(0, 'h7FF));
        if ($urandom_range(0, 19) == 0)
            len = LEN_W'($urandom);
        else if (op == OP_ENQ_FD && $urandom_range(0, 3) == 0)
            len = LEN_W'(fd_len_edges[$urandom_range(0, 15)]);
        else if (op == OP_ENQ_FD)
            len = LEN_W'($urandom_range(0, 64));
        else
            len = LEN_W'($urandom_range(0, 8));
        push_cmd(op, id, ext, 1'($urandom_range(0, 1)), len, TAG_W'($urandom),
                 $urandom_range(0, 3) != 0);
    endtask

    initial
    begin
        int items;
        int enq_pct;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_CONFIGURED;
        cfg_wdata      <= '0;
        opcode         <= OP_ENQ_CLASSIC;
        frame_id       <= '0;
        extended_id    <= 1'b0;
        remote_request <= 1'b0;
        payload_length <= '0;
        buffer_tag     <= '0;
        hw_accepts     <= 1'b0;
        idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not configured wins over bad identifier and length
        push_cmd(OP_ENQ_CLASSIC, 29'h800, 1'b0, 1'b0, 7'd127, 8'h00, 1'b1);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_RESERVED, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);

        load_regs(1'b1, 1'b0, 1'b0, 1'b0);
        push_cmd(OP_ENQ_FD, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_ENQ_CLASSIC, 29'h7FF, 1'b0, 1'b1, 7'd8, 8'h00, 1'b1);
        push_cmd(OP_ENQ_CLASSIC, 29'h800, 1'b0, 1'b0, 7'd0, 8'h11, 1'b1);
        push_cmd(OP_ENQ_CLASSIC, 29'h1FFFFFFF, 1'b1, 1'b0, 7'd0, 8'hFF, 1'b1);
        push_cmd(OP_ENQ_CLASSIC, 29'h5, 1'b0, 1'b0, 7'd9, 8'h22, 1'b1);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b0);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_RESERVED, 29'h1FFFFFFF, 1'b1, 1'b1, 7'd127, 8'hFF, 1'b1);

        load_regs(1'b1, 1'b1, 1'b1, 1'b1);
        // remote flag on an fd frame must not show up
        push_cmd(OP_ENQ_FD, 29'h1FFFFFFF, 1'b1, 1'b1, 7'd64, 8'h5A, 1'b1);
        push_cmd(OP_ENQ_FD, 29'h123, 1'b0, 1'b0, 7'd65, 8'h33, 1'b1);
        push_cmd(OP_ENQ_FD, 29'h7FF, 1'b0, 1'b0, 7'd9, 8'h44, 1'b1);
        push_cmd(OP_ENQ_CLASSIC, 29'h0, 1'b0, 1'b0, 7'd0, 8'hA5, 1'b1);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b0);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b0);

        // fd off: the held fd frame is skipped and fd enqueues are refused first
        load_regs(1'b1, 1'b0, 1'b0, 1'b0);
        push_cmd(OP_OFFER, 29'h0, 1'b0, 1'b0, 7'd0, 8'h00, 1'b1);
        push_cmd(OP_ENQ_FD, 29'h800, 1'b0, 1'b0, 7'd127, 8'h00, 1'b1);
        push_cmd(OP_ENQ_CLASSIC, 29'h800, 1'b0, 1'b0, 7'd127, 8'h00, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2], phase_regs[p][3]);
            idle_pct = phase_idle[p];
            items = phase_regs[p][0] ? PHASE_ITEMS : UNCFG_ITEMS;
            enq_pct = 50;
            for (int i = 0; i < items; i++)
            begin
                if (i % BURST_ITEMS == 0)
                    enq_pct = $urandom_range(20, 85);
                random_item(enq_pct);
            end
        end

        idle_pct = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d transfers (%0d enqueues, %0d slot offers, %0d reserved)",
                 n_enq + n_offer + n_reserved, n_enq, n_offer, n_reserved);
        $display("over %0d settings; checked %0d results, %0d held for retry, %0d full refusals",
                 n_settings, checked, holds, fulls);
        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("failures: %0d, results still expected: %0d", fail_count, pending);
            $display("status: fail");
        end
        $finish;
    end

endmodule
